>>> rtl/core/fdpd_pkg.sv
// fdpd_pkg: shared constants, word types and the cordic arctangent table
// for the folded disc polar distance pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fdpd_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int FRAC_BITS        = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int WR_WIDTH         = 30;
  localparam int SQ_IN_W          = 64;
  localparam int SQ_OUT_W         = 32;
  localparam int ANG_W            = 32;
  localparam int CORDIC_W         = 64;
  localparam int PRESHIFT         = 60 - COORD_WIDTH;
  localparam int DIST_W           = 32;

  localparam logic [WR_WIDTH-1:0] WR_RESET  = 30'd2560000;
  localparam logic [ANG_W-1:0]    HALF_TURN = 32'h8000_0000;
  localparam logic [17:0]         PI_Q16    = 18'd205887;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_height;
    logic signed [COORD_WIDTH-1:0] bz;
  } fdpd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_res;
    logic              saturated;
  } fdpd_out_t;

  // arctangent of 2^-i as a fraction of a full turn
  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fdpd_isqrt.sv
// fdpd_isqrt: pipelined floor square root, one result bit per stage
// depends on fdpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdpd_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [fdpd_pkg::SQ_IN_W-1:0]  rad_i,
  output logic                               valid_o,
  output logic      [fdpd_pkg::SQ_OUT_W-1:0] root_o
);
  import fdpd_pkg::*;

  localparam int N = SQ_OUT_W;

  logic               vld_q [N];
  logic [SQ_IN_W-1:0] rem_q [N];
  logic [SQ_IN_W-1:0] res_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
    logic [SQ_IN_W-1:0] rem_in;
    logic [SQ_IN_W-1:0] res_in;
    logic [SQ_IN_W-1:0] trial;
    logic               vld_in;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = res_q[N-1][N-1:0];

endmodule

`default_nettype wire

>>> rtl/core/fdpd_cordic.sv
// fdpd_cordic: pipelined vectoring cordic giving the binary angle of (x, z)
// depends on fdpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdpd_cordic #(
  parameter int CORDIC_STEPS = fdpd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic signed [fdpd_pkg::COORD_WIDTH-1:0] x_i,
  input  wire logic signed [fdpd_pkg::COORD_WIDTH-1:0] z_i,
  output logic             [fdpd_pkg::ANG_W-1:0]       ang_o
);
  import fdpd_pkg::*;

  logic signed [CORDIC_W-1:0] x_q    [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] z_q    [CORDIC_STEPS+1];
  logic        [ANG_W-1:0]    ang_q  [CORDIC_STEPS+1];
  logic                       zero_q [CORDIC_STEPS+1];

  logic signed [CORDIC_W-1:0] x_ext;
  logic signed [CORDIC_W-1:0] z_ext;

  assign x_ext = $signed({{(CORDIC_W-COORD_WIDTH){x_i[COORD_WIDTH-1]}}, x_i}) <<< PRESHIFT;
  assign z_ext = $signed({{(CORDIC_W-COORD_WIDTH){z_i[COORD_WIDTH-1]}}, z_i}) <<< PRESHIFT;

  // scale and rotate into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (z_i == '0);
      if (x_i[COORD_WIDTH-1]) begin
        x_q[0]   <= -x_ext;
        z_q[0]   <= -z_ext;
        ang_q[0] <= HALF_TURN;
      end else begin
        x_q[0]   <= x_ext;
        z_q[0]   <= z_ext;
        ang_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] zs;

    assign xs = x_q[i] >>> i;
    assign zs = z_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!z_q[i][CORDIC_W-1]) begin
          x_q[i+1]   <= x_q[i] + zs;
          z_q[i+1]   <= z_q[i] - xs;
          ang_q[i+1] <= ang_q[i] + atan_turn(5'(i));
        end else begin
          x_q[i+1]   <= x_q[i] - zs;
          z_q[i+1]   <= z_q[i] + xs;
          ang_q[i+1] <= ang_q[i] - atan_turn(5'(i));
        end
      end
    end
  end

  // origin point has angle zero
  assign ang_o = zero_q[CORDIC_STEPS] ? '0 : ang_q[CORDIC_STEPS];

endmodule

`default_nettype wire

>>> rtl/core/folded_disc_polar_distance.sv
// Folded disc distance between two 3-D points, fully pipelined: one pair word
// can be taken every cycle while the output buffer is not full, and one result
// word leaves per cycle while the receiver is ready. The depth does not depend
// on CORDIC_STEPS; it is set by the 32-step restoring square root units (radius
// and final distance) and the 32-step radius modulo chain. A two-word output
// buffer keeps input flowing while a result waits; when it is full the whole
// pipeline holds. The disc radius is written through cfg_we_i and must only
// change while no word is in flight. Depends on fdpd_pkg, fdpd_isqrt and
// fdpd_cordic.
`timescale 1ns / 1ps
`default_nettype none

module folded_disc_polar_distance #(
  parameter int CORDIC_STEPS = fdpd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire fdpd_pkg::fdpd_in_t                in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output fdpd_pkg::fdpd_out_t                    out_word_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [fdpd_pkg::WR_WIDTH-1:0]     cfg_wdata_i
);
  import fdpd_pkg::*;

  localparam int COR_LAT    = CORDIC_STEPS + 1;
  localparam int MOD_STEPS  = SQ_OUT_W;
  localparam int MEAN_STAGE = 1 + SQ_OUT_W + MOD_STEPS + 2;
  localparam int D_LEN      = MEAN_STAGE - COR_LAT;
  localparam int H_LEN      = MEAN_STAGE + 2;
  localparam int SAT_LEN    = SQ_OUT_W;
  localparam logic [WR_WIDTH-1:0] MEAN_MIN = WR_WIDTH'(1) << FRAC_BITS;

  logic adv;

  // configuration
  logic [WR_WIDTH-1:0] wr_q;
  logic [WR_WIDTH-1:0] wr_eff;
  logic [WR_WIDTH:0]   w2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= WR_RESET;
    end else if (cfg_we_i) begin
      wr_q <= cfg_wdata_i;
    end
  end

  assign wr_eff = (wr_q == '0) ? WR_WIDTH'(1) : wr_q;
  assign w2     = {wr_eff, 1'b0};

  // stage 1: squared horizontal radii and height difference
  logic [COORD_WIDTH-1:0] uax, uaz, ubx, ubz;
  logic [COORD_WIDTH:0]   hdiff;
  logic [COORD_WIDTH-1:0] hgt_d;
  logic                   v1_q;
  logic [SQ_IN_W-1:0]     sqa_q, sqb_q;

  assign uax   = in_word_i.ax[COORD_WIDTH-1] ? COORD_WIDTH'(-in_word_i.ax) : in_word_i.ax;
  assign uaz   = in_word_i.az[COORD_WIDTH-1] ? COORD_WIDTH'(-in_word_i.az) : in_word_i.az;
  assign ubx   = in_word_i.bx[COORD_WIDTH-1] ? COORD_WIDTH'(-in_word_i.bx) : in_word_i.bx;
  assign ubz   = in_word_i.bz[COORD_WIDTH-1] ? COORD_WIDTH'(-in_word_i.bz) : in_word_i.bz;
  assign hdiff = {in_word_i.ay[COORD_WIDTH-1], in_word_i.ay}
               - {in_word_i.by_height[COORD_WIDTH-1], in_word_i.by_height};
  assign hgt_d = hdiff[COORD_WIDTH] ? COORD_WIDTH'(-hdiff) : hdiff[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqa_q <= SQ_IN_W'(uax) * SQ_IN_W'(uax) + SQ_IN_W'(uaz) * SQ_IN_W'(uaz);
      sqb_q <= SQ_IN_W'(ubx) * SQ_IN_W'(ubx) + SQ_IN_W'(ubz) * SQ_IN_W'(ubz);
    end
  end

  // radius roots
  logic                vr_a;
  logic [SQ_OUT_W-1:0] root_a, root_b;

  fdpd_isqrt u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v1_q),
    .rad_i   (sqa_q),
    .valid_o (vr_a),
    .root_o  (root_a)
  );

  fdpd_isqrt u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v1_q),
    .rad_i   (sqb_q),
    .valid_o (),
    .root_o  (root_b)
  );

  // angles and folded angular difference
  logic [ANG_W-1:0] ang_a, ang_b, dd, d_d;
  logic [ANG_W-1:0] d_line_q [D_LEN];

  fdpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (in_word_i.ax),
    .z_i   (in_word_i.az),
    .ang_o (ang_a)
  );

  fdpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (in_word_i.bx),
    .z_i   (in_word_i.bz),
    .ang_o (ang_b)
  );

  assign dd  = ang_a - ang_b;
  assign d_d = (dd > HALF_TURN) ? ANG_W'(-dd) : dd;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_line_q[0] <= d_d;
      for (int i = 1; i < D_LEN; i++) begin
        d_line_q[i] <= d_line_q[i-1];
      end
    end
  end

  // height delay line
  logic [COORD_WIDTH-1:0] h_line_q [H_LEN];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_line_q[0] <= hgt_d;
      for (int i = 1; i < H_LEN; i++) begin
        h_line_q[i] <= h_line_q[i-1];
      end
    end
  end

  // radius modulo twice the world radius, one quotient bit per stage
  logic                mv_q  [MOD_STEPS];
  logic [SQ_OUT_W-1:0] num_q [MOD_STEPS][2];
  logic [WR_WIDTH:0]   rem_q [MOD_STEPS][2];

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic v_in;

    if (j == 0) begin : g_first
      assign v_in = vr_a;
    end else begin : g_next
      assign v_in = mv_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[j] <= 1'b0;
      end else if (adv) begin
        mv_q[j] <= v_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SQ_OUT_W-1:0] num_in;
      logic [WR_WIDTH:0]   rem_in;
      logic [WR_WIDTH+1:0] sh;

      if (j == 0) begin : g_first
        assign num_in = (l == 0) ? root_a : root_b;
        assign rem_in = '0;
      end else begin : g_next
        assign num_in = num_q[j-1][l];
        assign rem_in = rem_q[j-1][l];
      end

      assign sh = {rem_in, num_in[SQ_OUT_W-1]};

      always_ff @(posedge clk_i) begin
        if (adv) begin
          num_q[j][l] <= num_in << 1;
          if (sh >= {1'b0, w2}) begin
            rem_q[j][l] <= (WR_WIDTH+1)'(sh - {1'b0, w2});
          end else begin
            rem_q[j][l] <= sh[WR_WIDTH:0];
          end
        end
      end
    end
  end

  // fold, mean and radial difference
  logic                vf_q, vm_q;
  logic [WR_WIDTH-1:0] fa_q, fb_q, mean_q, rad_m_q;
  logic [WR_WIDTH:0]   ma, mb, fsum;
  logic [WR_WIDTH-1:0] mean_d;

  assign ma     = rem_q[MOD_STEPS-1][0];
  assign mb     = rem_q[MOD_STEPS-1][1];
  assign fsum   = {1'b0, fa_q} + {1'b0, fb_q};
  assign mean_d = fsum[WR_WIDTH:1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q    <= (ma > {1'b0, wr_eff}) ? WR_WIDTH'(w2 - ma) : ma[WR_WIDTH-1:0];
      fb_q    <= (mb > {1'b0, wr_eff}) ? WR_WIDTH'(w2 - mb) : mb[WR_WIDTH-1:0];
      mean_q  <= (mean_d < MEAN_MIN) ? MEAN_MIN : mean_d;
      rad_m_q <= (fa_q >= fb_q) ? fa_q - fb_q : fb_q - fa_q;
    end
  end

  // angular term
  localparam int P1_W = WR_WIDTH + ANG_W;
  localparam int P2_W = P1_W - 15 + 18;

  logic                vp1_q, vp2_q;
  logic [P1_W-1:0]     p1_q;
  logic [P2_W-1:0]     p2_full;
  logic [ANG_W-1:0]    ang_q;
  logic [WR_WIDTH-1:0] rad_p1_q, rad_p2_q;

  assign p2_full = P2_W'(p1_q[P1_W-1:15]) * P2_W'(PI_Q16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= P1_W'(mean_q) * P1_W'(d_line_q[D_LEN-1]);
      rad_p1_q <= rad_m_q;
      ang_q    <= p2_full[63:32];
      rad_p2_q <= rad_p1_q;
    end
  end

  // squares and sum
  logic                vq_q, vs_q;
  logic [SQ_IN_W-1:0]  aa_q, rr_q, hh_q, s_q;
  logic [SQ_IN_W+1:0]  tot;
  logic                sat_q;
  logic                sat_line_q [SAT_LEN];

  assign tot = {2'b0, aa_q} + {2'b0, rr_q} + {2'b0, hh_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      aa_q  <= SQ_IN_W'(ang_q) * SQ_IN_W'(ang_q);
      rr_q  <= SQ_IN_W'(rad_p2_q) * SQ_IN_W'(rad_p2_q);
      hh_q  <= SQ_IN_W'(h_line_q[H_LEN-1]) * SQ_IN_W'(h_line_q[H_LEN-1]);
      s_q   <= tot[SQ_IN_W-1:0];
      sat_q <= |tot[SQ_IN_W+1:SQ_IN_W];
      sat_line_q[0] <= sat_q;
      for (int i = 1; i < SAT_LEN; i++) begin
        sat_line_q[i] <= sat_line_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q  <= 1'b0;
      vm_q  <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vq_q  <= 1'b0;
      vs_q  <= 1'b0;
    end else if (adv) begin
      vf_q  <= mv_q[MOD_STEPS-1];
      vm_q  <= vf_q;
      vp1_q <= vm_q;
      vp2_q <= vp1_q;
      vq_q  <= vp2_q;
      vs_q  <= vq_q;
    end
  end

  // final root
  logic                vfin;
  logic [SQ_OUT_W-1:0] root_f;

  fdpd_isqrt u_sqrt_f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vs_q),
    .rad_i   (s_q),
    .valid_o (vfin),
    .root_o  (root_f)
  );

  // two-word output buffer
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       push, pop;
  fdpd_out_t  res_word;
  fdpd_out_t  buf_q [2];

  assign adv      = (cnt_q != 2'd2);
  assign push     = adv && vfin;
  assign pop      = out_valid_o && out_ready_i;
  assign res_word = '{dist_res: sat_line_q[SAT_LEN-1] ? '1 : root_f,
                      saturated: sat_line_q[SAT_LEN-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= res_word;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = buf_q[rp_q];

endmodule

`default_nettype wire

>>> dv/tb.sv
// tb: self-checking testbench for folded_disc_polar_distance, directed table then
// random pairs, each result checked against its known table value or an in-bench
// distance predictor; depends on fdpd_pkg and the folded_disc_polar_distance rtl
`timescale 1ns / 1ps

module tb;
  import fdpd_pkg::*;

  typedef struct {
    fdpd_in_t  w;
    bit        known;
    fdpd_out_t res;
  } row_t;

  typedef struct {
    bit        known;
    fdpd_out_t res;
  } hint_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [WR_WIDTH-1:0] cfg_wdata_i = '0;
  fdpd_in_t in_word_i = '0;
  logic in_ready_o, out_valid_o;
  fdpd_out_t out_word_o;

  fdpd_out_t dist_due[$];
  hint_t hint_q[$];
  row_t rows[$];
  logic [WR_WIDTH-1:0] world_r = WR_RESET;
  int errors = 0;
  int n_taken = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  folded_disc_polar_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit [63:0] isqrt_floor(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [31:0] binary_angle(longint x, longint z);
    bit [31:0] a;
    longint xs, zs;
    a = 0;
    if (x == 0 && z == 0) return 0;
    x = x * (64'sd1 <<< PRESHIFT);
    z = z * (64'sd1 <<< PRESHIFT);
    if (x < 0) begin
      x = -x;
      z = -z;
      a = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      zs = z >>> i;
      if (z >= 0) begin
        x = x + zs;
        z = z - xs;
        a = a + atan_turn(i[4:0]);
      end else begin
        x = x - zs;
        z = z + xs;
        a = a - atan_turn(i[4:0]);
      end
    end
    return a;
  endfunction

  function automatic bit [63:0] fold_radius(longint x, longint z, bit [63:0] wr);
    bit [63:0] ux, uz, r, m;
    ux = (x < 0) ? -x : x;
    uz = (z < 0) ? -z : z;
    r = isqrt_floor(ux * ux + uz * uz);
    m = r % (2 * wr);
    if (m > wr) m = 2 * wr - m;
    return m;
  endfunction

  function automatic fdpd_out_t predict_distance(fdpd_in_t w, logic [WR_WIDTH-1:0] wreg);
    bit [63:0] wr, ra, rb, mean, ang, rad, hgt, s, t, u;
    bit [31:0] d;
    longint ay, by;
    fdpd_out_t o;
    wr = (wreg == 0) ? 64'd1 : 64'(wreg);
    ra = fold_radius(longint'(w.ax), longint'(w.az), wr);
    rb = fold_radius(longint'(w.bx), longint'(w.bz), wr);
    d = binary_angle(longint'(w.ax), longint'(w.az)) - binary_angle(longint'(w.bx), longint'(w.bz));
    if (d > HALF_TURN) d = -d;
    mean = (ra + rb) >> 1;
    if (mean < (64'd1 << FRAC_BITS)) mean = 64'd1 << FRAC_BITS;
    ang = (((mean * 64'(d)) >> 15) * 64'(PI_Q16)) >> 32;
    rad = (ra >= rb) ? ra - rb : rb - ra;
    ay = longint'(w.ay);
    by = longint'(w.by_height);
    hgt = (ay >= by) ? 64'(ay - by) : 64'(by - ay);
    s = ang * ang;
    t = s + rad * rad;
    u = t + hgt * hgt;
    if (t < s || u < t) begin
      o.dist_res = '1;
      o.saturated = 1'b1;
    end else begin
      o.dist_res = 32'(isqrt_floor(u));
      o.saturated = 1'b0;
    end
    return o;
  endfunction

  function automatic longint near_coord(longint span);
    bit [63:0] m;
    m = {$urandom, $urandom} % (2 * span + 1);
    return longint'(m) - span;
  endfunction

  function automatic fdpd_in_t rand_pair(logic [WR_WIDTH-1:0] wreg);
    fdpd_in_t w;
    longint span;
    if ($urandom_range(9) < 3) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      span = longint'(wreg) * 3 + 1;
      if (span > 2147483647) span = 2147483647;
      w.ax = COORD_WIDTH'(near_coord(span));
      w.az = COORD_WIDTH'(near_coord(span));
      w.bx = COORD_WIDTH'(near_coord(span));
      w.bz = COORD_WIDTH'(near_coord(span));
      w.ay = COORD_WIDTH'(near_coord(1 << 20));
      w.by_height = COORD_WIDTH'(near_coord(1 << 20));
    end
    return w;
  endfunction

  task automatic add_row(fdpd_in_t w, bit known, fdpd_out_t res);
    row_t r;
    r.w = w;
    r.known = known;
    r.res = res;
    rows.insert(rows.size(), r);
  endtask

  task automatic send_word(fdpd_in_t w, bit known, fdpd_out_t res);
    hint_t h;
    if (!no_idle) begin
      while ($urandom_range(99) < 27) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    h.known = known;
    h.res = res;
    hint_q.insert(hint_q.size(), h);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_radius(logic [WR_WIDTH-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dist_due.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    world_r = v;
  endtask

  // receiver side, with one long hold-off to back the pipeline up
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!held && n_taken >= 200) begin
        held = 1;
        hold = 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    fdpd_out_t e;
    hint_t h;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        h = hint_q.pop_front();
        dist_due.insert(dist_due.size(),
                        h.known ? h.res : predict_distance(in_word_i, world_r));
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (dist_due.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = dist_due.pop_front();
          if (out_word_o.dist_res !== e.dist_res) begin
            $error("dist_res exp %h got %h", e.dist_res, out_word_o.dist_res);
            errors++;
          end
          if (out_word_o.saturated !== e.saturated) begin
            $error("saturated exp %b got %b", e.saturated, out_word_o.saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [WR_WIDTH-1:0] radii[6];
    fdpd_in_t w;
    fdpd_out_t z;
    fdpd_out_t sat_res;
    z = '0;
    sat_res = '{dist_res: '1, saturated: 1'b1};
    radii = '{WR_RESET, 30'd0, 30'd1, 30'h3FFF_FFFF, 30'd1000, 30'd0};
    radii[5] = WR_WIDTH'($urandom_range(2, 30'h3FFF_FFFE));

    // directed rows
    add_row('0, 1'b1, z);
    w = '{ax: 1000, ay: 5, az: -77, bx: 1000, by_height: 5, bz: -77};
    add_row(w, 1'b1, z);
    w = '{ax: 0, ay: 0, az: 0, bx: 0, by_height: 1000, bz: 0};
    add_row(w, 1'b1, '{dist_res: 32'd1000, saturated: 1'b0});
    w = '{ax: 0, ay: 32'sh8000_0000, az: 0, bx: 0, by_height: 32'sh7FFF_FFFF, bz: 0};
    add_row(w, 1'b1, '{dist_res: '1, saturated: 1'b0});
    w = '{ax: 0, ay: 32'sh8000_0000, az: 0, bx: 100000, by_height: 32'sh7FFF_FFFF, bz: 0};
    add_row(w, 1'b1, sat_res);
    w = '{ax: 32'sh7FFF_FFFF, ay: 32'sh7FFF_FFFF, az: 32'sh7FFF_FFFF,
          bx: 32'sh8000_0000, by_height: 32'sh8000_0000, bz: 32'sh8000_0000};
    add_row(w, 1'b0, z);
    w = '{ax: 32'sh8000_0000, ay: 0, az: 32'sh8000_0000,
          bx: 32'sh7FFF_FFFF, by_height: 0, bz: 32'sh8000_0000};
    add_row(w, 1'b0, z);
    w = '{ax: -5000, ay: 0, az: 0, bx: 5000, by_height: 0, bz: 0};
    add_row(w, 1'b0, z);
    w = '{ax: 0, ay: 0, az: 5000, bx: 0, by_height: 0, bz: -5000};
    add_row(w, 1'b0, z);
    w = '{ax: -5000, ay: 0, az: -1, bx: -5000, by_height: 0, bz: 1};
    add_row(w, 1'b0, z);
    w = '{ax: 5120000, ay: 0, az: 0, bx: 0, by_height: 0, bz: 3000};
    add_row(w, 1'b0, z);
    w = '{ax: 2560000, ay: 0, az: 0, bx: -2560001, by_height: 0, bz: 0};
    add_row(w, 1'b0, z);
    w = '{ax: 3000000, ay: -9, az: 1, bx: 10, by_height: 9, bz: -400};
    add_row(w, 1'b0, z);
    w = '{ax: 1, ay: 0, az: 0, bx: 0, by_height: 0, bz: 1};
    add_row(w, 1'b0, z);
    w = '{ax: 7680000, ay: 0, az: 0, bx: -7680000, by_height: 0, bz: 0};
    add_row(w, 1'b0, z);
    w = '{ax: 32'sh7FFF_FFFF, ay: 0, az: 0, bx: 0, by_height: 0, bz: 32'sh7FFF_FFFF};
    add_row(w, 1'b0, z);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 6; p++) begin
      write_radius(radii[p]);
      no_idle = (p == 3);
      if (p == 0) begin
        foreach (rows[i]) send_word(rows[i].w, rows[i].known, rows[i].res);
      end
      repeat (280) send_word(rand_pair(world_r), 1'b0, z);
      no_idle = 1'b0;
    end
    in_valid_i <= 1'b0;
    while (dist_due.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
